// File: rtl/sbva_pkg.sv
package sbva_pkg;

	localparam int CODE_W = 12;
	localparam int GAIN_W = 20;
	localparam int MV_W = 16;
	localparam int PROD_W = CODE_W + GAIN_W;
	localparam int FRAC_W = 16;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 20'd880497;

	localparam int DEPTH_DEF = 8;
	localparam int SHIFT_DEF = 3;

	// the product stays below 2**32, so the integer part always fits 16 bits
	function automatic logic [MV_W-1:0] scale_code(
		input logic [CODE_W-1:0] code,
		input logic [GAIN_W-1:0] gain
	);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(code) * PROD_W'(gain);
		return prod[FRAC_W +: MV_W];
	endfunction

endpackage

// File: rtl/scaled_boxcar_voltage_average.sv
// Scaled boxcar voltage average. Each request carries one 12-bit converter
// code; it is scaled to millivolts by the 20-bit Q16 gain register (reset
// value about 13.4353 mV per code, fraction truncated) and returned as
// scaled_mv together with average_mv, the sum of the last DEPTH scaled
// samples shifted right by SHIFT (low 16 bits kept). The first sample after
// reset stands for the whole window. One request is accepted every cycle
// unless a held result (out_ready low) stalls the pipeline; a result passes
// the input register, the multiplier register and the result register, and
// the window sum is updated from a running total and a ring memory read
// one entry ahead. No clearing pass is needed after reset. The user must
// write the gain through the cfg port, which is always ready, only while
// the block is idle; the block itself does not enforce this.
module scaled_boxcar_voltage_average #(
	parameter int DEPTH = sbva_pkg::DEPTH_DEF,
	parameter int SHIFT = sbva_pkg::SHIFT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [sbva_pkg::GAIN_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [sbva_pkg::CODE_W-1:0] adc_code,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [sbva_pkg::MV_W-1:0]   average_mv,
	output logic [sbva_pkg::MV_W-1:0]   scaled_mv
);

	logic                      s_valid;
	logic                      s_ready;
	logic [sbva_pkg::MV_W-1:0] s_mv;

	assign cfg_ready = 1'b1;

	sbva_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.adc_code  (adc_code),
		.s_valid   (s_valid),
		.s_ready   (s_ready),
		.s_mv      (s_mv)
	);

	sbva_window #(
		.DEPTH (DEPTH),
		.SHIFT (SHIFT)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_valid    (s_valid),
		.s_ready    (s_ready),
		.s_mv       (s_mv),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.average_mv (average_mv),
		.scaled_mv  (scaled_mv)
	);

endmodule

// File: rtl/sbva_scale.sv
module sbva_scale (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [sbva_pkg::GAIN_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sbva_pkg::CODE_W-1:0]   adc_code,
	output logic                          s_valid,
	input  logic                          s_ready,
	output logic [sbva_pkg::MV_W-1:0]     s_mv
);

	logic [sbva_pkg::GAIN_W-1:0] gain_q;
	logic                        valid_s1;
	logic [sbva_pkg::CODE_W-1:0] code_s1;
	logic                        valid_s2;
	logic [sbva_pkg::MV_W-1:0]   mv_s2;
	logic                        en_s2;

	assign en_s2 = !valid_s2 || s_ready;
	assign in_ready = !valid_s1 || en_s2;
	assign s_valid = valid_s2;
	assign s_mv = mv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= sbva_pkg::GAIN_RESET;
		end else if (cfg_valid) begin
			gain_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			code_s1 <= adc_code;
		end
		if (en_s2 && valid_s1) begin
			mv_s2 <= sbva_pkg::scale_code(code_s1, gain_q);
		end
	end

endmodule

// File: rtl/sbva_window.sv
module sbva_window #(
	parameter int DEPTH = sbva_pkg::DEPTH_DEF,
	parameter int SHIFT = sbva_pkg::SHIFT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_valid,
	output logic                      s_ready,
	input  logic [sbva_pkg::MV_W-1:0] s_mv,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [sbva_pkg::MV_W-1:0] average_mv,
	output logic [sbva_pkg::MV_W-1:0] scaled_mv
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SUM_W = sbva_pkg::MV_W + $clog2(DEPTH);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

	logic [sbva_pkg::MV_W-1:0] ring_mem [DEPTH];
	logic [sbva_pkg::MV_W-1:0] rd_q;
	logic [sbva_pkg::MV_W-1:0] first_mv_q;
	logic [IDX_W-1:0]          idx_q;
	logic [SUM_W-1:0]          sum_q;
	logic                      started_q;
	logic                      lap_q;
	logic                      out_valid_q;
	logic [sbva_pkg::MV_W-1:0] avg_q;
	logic [sbva_pkg::MV_W-1:0] mv_out_q;

	logic                      fire;
	logic                      idx_last;
	logic [IDX_W-1:0]          idx_inc;
	logic [IDX_W-1:0]          rd_addr;
	logic [sbva_pkg::MV_W-1:0] old_mv;
	logic [SUM_W-1:0]          sum_nxt;
	logic [SUM_W-1:0]          avg_full;

	assign s_ready = !out_valid_q || out_ready;
	assign fire = s_valid && s_ready;
	assign idx_last = (idx_q == IDX_LAST);
	assign idx_inc = idx_last ? '0 : idx_q + 1'b1;
	// read one entry ahead so the old sample is ready for the next request
	assign rd_addr = (fire && started_q) ? idx_inc : idx_q;
	// on the first lap the entry being replaced stands for the first sample
	assign old_mv = lap_q ? first_mv_q : rd_q;

	always_comb begin
		if (started_q) begin
			sum_nxt = sum_q - SUM_W'(old_mv) + SUM_W'(s_mv);
		end else begin
			sum_nxt = SUM_W'(s_mv) * SUM_W'(DEPTH);
		end
	end

	assign avg_full = sum_nxt >> SHIFT;

	assign out_valid = out_valid_q;
	assign average_mv = avg_q;
	assign scaled_mv = mv_out_q;

	always_ff @(posedge clk) begin
		if (fire && started_q) begin
			ring_mem[idx_q] <= s_mv;
		end
		rd_q <= ring_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			lap_q <= 1'b0;
			idx_q <= '0;
			sum_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_ready) begin
				out_valid_q <= s_valid;
			end
			if (fire) begin
				sum_q <= sum_nxt;
				if (!started_q) begin
					started_q <= 1'b1;
					lap_q <= 1'b1;
				end else begin
					idx_q <= idx_inc;
					if (idx_last) begin
						lap_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			avg_q <= avg_full[sbva_pkg::MV_W-1:0];
			mv_out_q <= s_mv;
			if (!started_q) begin
				first_mv_q <= s_mv;
			end
		end
	end

endmodule

// File: rtl/sbva_checker.sv
module sbva_props (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cfg_valid,
	input logic                        cfg_ready,
	input logic [sbva_pkg::GAIN_W-1:0] cfg_data,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [sbva_pkg::CODE_W-1:0] adc_code,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [sbva_pkg::MV_W-1:0]   average_mv,
	input logic [sbva_pkg::MV_W-1:0]   scaled_mv
);

	localparam logic [1:0] CAP = 2'd3;

	logic [1:0] pend_q;
	logic       in_fire;
	logic       out_fire;

	assign in_fire = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// requests in flight: input register, multiplier register, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, in_fire} - {1'b0, out_fire};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(average_mv) && $stable(scaled_mv))
		else $error("result changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result without a pending request");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == CAP && !out_ready |-> !in_ready)
		else $error("request taken with pipeline full");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(adc_code))
		else $error("request dropped or changed while waiting");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready && !$isunknown(cfg_data))
		else $error("cfg write not taken");

endmodule

bind scaled_boxcar_voltage_average sbva_props u_sbva_props (.*);

// File: sim/sbva_checker.sv
module sbva_checker #(
	parameter int DEPTH = sbva_pkg::DEPTH_DEF,
	parameter int SHIFT = sbva_pkg::SHIFT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [sbva_pkg::GAIN_W-1:0] cfg_data,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [sbva_pkg::CODE_W-1:0] adc_code,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [sbva_pkg::MV_W-1:0]   average_mv,
	input  logic [sbva_pkg::MV_W-1:0]   scaled_mv,
	output int                          errors,
	output int                          outstanding
);

	typedef struct packed {
		logic [sbva_pkg::MV_W-1:0] average;
		logic [sbva_pkg::MV_W-1:0] scaled;
	} mv_pair_t;

	logic [sbva_pkg::GAIN_W-1:0] gain;
	logic [sbva_pkg::MV_W-1:0]   window [DEPTH];
	int unsigned                 slot;
	logic [31:0]                 window_total;
	bit                          primed;
	logic [sbva_pkg::MV_W-1:0]   sample;
	mv_pair_t                    head;
	mv_pair_t                    expected_mv [$];

	// truncate the q16 product, saturate at full scale
	function automatic logic [sbva_pkg::MV_W-1:0] mv_from_code(
		input logic [sbva_pkg::CODE_W-1:0] code,
		input logic [sbva_pkg::GAIN_W-1:0] gain_q16
	);
		logic [32:0] product;
		product = 33'(code) * 33'(gain_q16);
		if (product[32:16] > 17'h0FFFF) begin
			return '1;
		end
		return product[31:16];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain = sbva_pkg::GAIN_RESET;
			foreach (window[i]) window[i] = '0;
			slot = 0;
			window_total = '0;
			primed = 1'b0;
			expected_mv.delete();
			outstanding = 0;
			errors = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_mv.size() == 0) begin
					$error("unexpected result: average_mv %0d scaled_mv %0d",
						average_mv, scaled_mv);
					errors++;
				end else begin
					head = expected_mv.pop_front();
					if (average_mv !== head.average) begin
						$error("average_mv: expected %0d, got %0d", head.average, average_mv);
						errors++;
					end
					if (scaled_mv !== head.scaled) begin
						$error("scaled_mv: expected %0d, got %0d", head.scaled, scaled_mv);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				gain = cfg_data;
			end
			if (in_valid && in_ready) begin
				sample = mv_from_code(adc_code, gain);
				// first request after reset stands for the whole window
				if (!primed) begin
					foreach (window[i]) window[i] = sample;
					window_total = 32'(sample) * 32'(DEPTH);
					slot = 0;
					primed = 1'b1;
				end else begin
					window_total = window_total - 32'(window[slot]) + 32'(sample);
					window[slot] = sample;
					slot = (slot == DEPTH - 1) ? 0 : slot + 1;
				end
				head.average = 16'(window_total >> SHIFT);
				head.scaled = sample;
				expected_mv.push_back(head);
			end
			outstanding = expected_mv.size();
		end
	end

endmodule

// File: sim/tb_scaled_boxcar_voltage_average.sv
module tb_scaled_boxcar_voltage_average;

	localparam int DEPTH = sbva_pkg::DEPTH_DEF;
	localparam int SHIFT = sbva_pkg::SHIFT_DEF;

	typedef enum logic [1:0] {
		TRAFFIC_FULL,
		TRAFFIC_SEND_IDLE,
		TRAFFIC_RECV_STALL,
		TRAFFIC_BOTH
	} traffic_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [sbva_pkg::GAIN_W-1:0] cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [sbva_pkg::CODE_W-1:0] adc_code = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [sbva_pkg::MV_W-1:0]   average_mv;
	logic [sbva_pkg::MV_W-1:0]   scaled_mv;
	traffic_t                    traffic = TRAFFIC_FULL;
	int                          errors;
	int                          outstanding;

	scaled_boxcar_voltage_average #(
		.DEPTH(DEPTH),
		.SHIFT(SHIFT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.adc_code(adc_code),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.average_mv(average_mv),
		.scaled_mv(scaled_mv)
	);

	sbva_checker #(
		.DEPTH(DEPTH),
		.SHIFT(SHIFT)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.adc_code(adc_code),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.average_mv(average_mv),
		.scaled_mv(scaled_mv),
		.errors(errors),
		.outstanding(outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		case (traffic)
			TRAFFIC_RECV_STALL: out_ready <= $urandom_range(0, 99) >= 50;
			TRAFFIC_BOTH: out_ready <= $urandom_range(0, 99) >= 35;
			default: out_ready <= 1'b1;
		endcase
	end

	task automatic send_code(input logic [sbva_pkg::CODE_W-1:0] code);
		bit took;
		while ((traffic == TRAFFIC_SEND_IDLE && $urandom_range(0, 99) < 50)
			|| (traffic == TRAFFIC_BOTH && $urandom_range(0, 99) < 35)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		adc_code <= code;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
	endtask

	// gain changes only once the pipeline has drained
	task automatic set_gain(input logic [sbva_pkg::GAIN_W-1:0] gain);
		bit took;
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= gain;
		do begin
			@(negedge clk);
			took = cfg_ready;
			@(posedge clk);
		end while (!took);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [sbva_pkg::CODE_W-1:0] code;
		logic [sbva_pkg::GAIN_W-1:0] gain;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first request fills the window at full scale
		send_code(12'hFFF);
		send_code(12'h000);
		send_code(12'h001);
		send_code(12'h800);
		send_code(12'h7FF);
		send_code(12'hAAA);
		send_code(12'h555);
		repeat (4) send_code(12'hFFF);

		set_gain(20'hFFFFF);
		repeat (8) send_code(12'hFFF);
		send_code(12'h000);

		set_gain(20'h00000);
		send_code(12'hFFF);
		send_code(12'h123);

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: gain = 20'hFFFFF;
				1: gain = 20'h00000;
				2: gain = sbva_pkg::GAIN_RESET;
				3: gain = 20'h10000;
				default: gain = 20'($urandom);
			endcase
			set_gain(gain);
			traffic <= traffic_t'(phase % 4);
			repeat (154) begin
				if ($urandom_range(0, 7) == 0) begin
					code = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
				end else begin
					code = 12'($urandom);
				end
				send_code(code);
			end
		end

		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
		@(negedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
